/* rtl/rss_pkg.sv */
`default_nettype none
package rss_pkg;
  localparam int MaxRecords = 64;
  localparam int KeyChars = 8;
  localparam int AddrW = $clog2(MaxRecords);
  localparam int CntW = $clog2(MaxRecords + 1);
  localparam logic [63:0] KeyMask = ~64'd0 << (64 - 8 * KeyChars);

  typedef struct packed {
    logic [63:0] surname;
    logic [63:0] position;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [6:0]  experience;
    logic [63:0] salary;
  } rec_t;

  localparam int RecW = $bits(rec_t);

  function automatic logic rec_less(input rec_t a, input rec_t b);
    if (a.surname != b.surname) return a.surname < b.surname;
    return a.position < b.position;
  endfunction
endpackage
`default_nettype wire

/* rtl/record_shell_sort.sv */
// record_shell_sort: loads records, Shell sorts them (gaps n/2 .. 1) by
// surname then position, and emits them in order.
// Input channel in_*: one record per cycle is accepted while loading. The
// record with in_final_record set ends the set; records beyond 64 are dropped
// but a dropped final record still starts the sort.
// While sorting and emitting, in_stall is high.
// Sort: one record memory, one access per cycle. Each insertion reads the
// key element (S_RDI, S_WTI), then per compare step reads the element one
// gap below (S_RDJ, S_WTJ) and, in S_CMP, writes the moved element; S_PUT
// writes the key element into place. Total time is data dependent.
// Output channel out_*: one sorted record per cycle when out_stall is low,
// from a registered output stage; out_last marks the final record. The first
// record is valid once it has passed the memory read register and the buffer. Read
// latency is hidden by a two-entry buffer, so a stall never loses data.
// Reset (rst_n low, synchronous) empties the set and the output stage;
// memory contents are not cleared.
`default_nettype none
module record_shell_sort (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_surname_key,
  input  wire logic [63:0] in_position_key,
  input  wire logic [4:0]  in_birth_day,
  input  wire logic [3:0]  in_birth_month,
  input  wire logic [13:0] in_birth_year,
  input  wire logic [6:0]  in_years_worked,
  input  wire logic [63:0] in_salary_bits,
  input  wire logic        in_final_record,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_surname,
  output logic [63:0]      out_position,
  output logic [4:0]       out_day,
  output logic [3:0]       out_month,
  output logic [13:0]      out_year,
  output logic [6:0]       out_experience,
  output logic [63:0]      out_salary,
  output logic             out_last
);
  localparam int AW = rss_pkg::AddrW;
  localparam int CW = rss_pkg::CntW;

  typedef enum logic [3:0] {
    S_LOAD, S_GAP, S_RDI, S_WTI, S_RDJ, S_WTJ, S_CMP, S_PUT, S_EMIT
  } state_t;

  state_t state_r;
  logic [CW-1:0] cnt_r, gap_r, i_r, j_r, ocnt_r;
  rss_pkg::rec_t tmp_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  rss_pkg::rec_t wdata, rdata;

  rss_ram #(.Width(rss_pkg::RecW), .Depth(rss_pkg::MaxRecords)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Emit: read addresses issued, data lands in a 2-entry skid buffer.
  logic [CW-1:0] rd_r;       // next read index
  logic          pend_r;     // read in flight
  logic          pend_last_r;
  rss_pkg::rec_t buf_r [2];
  logic          buf_last_r [2];
  logic [1:0]    fill_r;
  logic          wp_r, rp_r;

  rss_pkg::rec_t in_rec;
  always_comb begin
    in_rec.surname    = in_surname_key & rss_pkg::KeyMask;
    in_rec.position   = in_position_key & rss_pkg::KeyMask;
    in_rec.day        = in_birth_day;
    in_rec.month      = in_birth_month;
    in_rec.year       = in_birth_year;
    in_rec.experience = in_years_worked;
    in_rec.salary     = in_salary_bits;
  end

  assign in_stall = (state_r != S_LOAD);
  wire in_acc  = in_valid && !in_stall;
  wire out_acc = out_valid && !out_stall;

  logic [1:0] occ;
  logic       issue;
  always_comb begin
    occ   = fill_r + {1'b0, pend_r};
    issue = (state_r == S_EMIT) && (rd_r < cnt_r) &&
            ((occ - {1'b0, out_acc}) < 2'd2);
  end

  always_comb begin
    we = 1'b0; waddr = '0; wdata = tmp_r; raddr = '0;
    unique case (state_r)
      S_LOAD: begin
        we = in_acc && (cnt_r < CW'(rss_pkg::MaxRecords));
        waddr = cnt_r[AW-1:0]; wdata = in_rec;
      end
      S_RDI: raddr = i_r[AW-1:0];
      // address held through the wait so rdata is still valid in S_CMP
      S_RDJ, S_WTJ: raddr = AW'(j_r - gap_r);
      S_CMP: begin
        we = rss_pkg::rec_less(tmp_r, rdata);
        waddr = j_r[AW-1:0]; wdata = rdata;
      end
      S_PUT: begin we = 1'b1; waddr = j_r[AW-1:0]; wdata = tmp_r; end
      S_EMIT: raddr = rd_r[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; gap_r <= '0; i_r <= '0; j_r <= '0;
      rd_r <= '0; pend_r <= 1'b0; fill_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
      ocnt_r <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: if (in_acc) begin
          if (cnt_r < CW'(rss_pkg::MaxRecords)) cnt_r <= cnt_r + 1'b1;
          if (in_final_record) begin
            gap_r <= ((cnt_r < CW'(rss_pkg::MaxRecords)) ? cnt_r + 1'b1 : cnt_r) >> 1;
            state_r <= S_GAP;
          end
        end
        S_GAP: begin
          if (gap_r == '0) begin
            state_r <= S_EMIT; rd_r <= '0; ocnt_r <= '0;
          end else begin
            i_r <= gap_r; state_r <= S_RDI;
          end
        end
        S_RDI: begin
          if (i_r >= cnt_r) begin
            gap_r <= gap_r >> 1; state_r <= S_GAP;
          end else begin
            j_r <= i_r; state_r <= S_WTI;
          end
        end
        S_WTI: begin tmp_r <= rdata; state_r <= S_RDJ; end
        S_RDJ: state_r <= (j_r >= gap_r) ? S_WTJ : S_PUT;
        S_WTJ: state_r <= S_CMP;
        S_CMP: begin
          if (rss_pkg::rec_less(tmp_r, rdata)) begin
            j_r <= j_r - gap_r; state_r <= S_RDJ;
          end else state_r <= S_PUT;
        end
        S_PUT: begin i_r <= i_r + 1'b1; state_r <= S_RDI; end
        S_EMIT: begin
          if (out_acc && ocnt_r == cnt_r - 1'b1) begin
            state_r <= S_LOAD; cnt_r <= '0;
          end
        end
        default: state_r <= S_LOAD;
      endcase

      if (issue) rd_r <= rd_r + 1'b1;
      pend_r <= issue;
      pend_last_r <= (rd_r == cnt_r - 1'b1);
      if (pend_r) begin
        buf_r[wp_r] <= rdata;
        buf_last_r[wp_r] <= pend_last_r;
        wp_r <= ~wp_r;
      end
      if (out_acc) begin
        rp_r <= ~rp_r;
        ocnt_r <= ocnt_r + 1'b1;
      end
      fill_r <= fill_r + {1'b0, pend_r} - {1'b0, out_acc};
    end
  end

  rss_pkg::rec_t head;
  assign head           = buf_r[rp_r];
  assign out_valid      = (fill_r != 2'd0);
  assign out_surname    = head.surname;
  assign out_position   = head.position;
  assign out_day        = head.day;
  assign out_month      = head.month;
  assign out_year       = head.year;
  assign out_experience = head.experience;
  assign out_salary     = head.salary;
  assign out_last       = buf_last_r[rp_r];
endmodule
`default_nettype wire

/* rtl/rss_ram.sv */
`default_nettype none
module rss_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  parameter int AW = $clog2(Depth)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
